>>> rtl/nmh_pkg.sv
// ---------------------------------------------------------------------------
// nmh_pkg
// Shared types and constants of the height-map-to-normal-map unit.
// ---------------------------------------------------------------------------
package nmh_pkg;

	// Map geometry: MAP_SIZE must be a power of two no larger than 256.
	localparam int MAP_SIZE  = 256;
	localparam int COORD_W   = $clog2(MAP_SIZE);
	localparam int ADDR_W    = 2 * COORD_W;
	localparam int MEM_DEPTH = MAP_SIZE * MAP_SIZE;

	localparam int FIELD_COORD_W = 8;
	localparam int HEIGHT_W      = 16;
	localparam int STRENGTH_W    = 16;
	localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 16'd256;

	// Datapath widths
	localparam int DIFF_W     = HEIGHT_W + 1;        // height difference
	localparam int PROD_W     = DIFF_W + STRENGTH_W; // slope, signed
	localparam int MAG_W      = PROD_W - 1;          // slope magnitude
	localparam int VEC_W      = 30;                  // normalized component magnitude
	localparam int UNIT_SHIFT = 20;                  // 1.0 in slope units
	localparam int SUM_W      = 2 * VEC_W + 2;       // sum of three squares
	localparam int LEN_W      = VEC_W + 1;           // vector length
	localparam int BYTE_W     = 8;
	localparam int NUM_W      = LEN_W + 1 + BYTE_W;  // encoder dividend
	localparam int ROOT_STEPS = LEN_W;
	localparam int LANES      = 3;

	// Queue between fetch and math; depth of two or more
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_READ  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                       kind;
		logic [FIELD_COORD_W-1:0]    col;
		logic [FIELD_COORD_W-1:0]    row;
		logic signed [HEIGHT_W-1:0]  height;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] normal_red;
		logic [BYTE_W-1:0] normal_green;
		logic [BYTE_W-1:0] normal_blue;
	} result_t;

	// Neighbor differences of one read, east minus west and south minus north
	typedef struct packed {
		logic signed [DIFF_W-1:0] dh_x;
		logic signed [DIFF_W-1:0] dh_y;
	} grad_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_WEST,
		F_SOUTH,
		F_NORTH,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_NORM,
		B_SQ,
		B_ROOT,
		B_ENC,
		B_DIV,
		B_DONE
	} back_state_t;

endpackage

>>> rtl/nmh_front.sv
// ---------------------------------------------------------------------------
// nmh_front
// Height store and neighbor fetch. Writes go to the store when accepted; a read
// fetches the four wrapped neighbors over the single memory port and pushes
// their differences to the queue.
// ---------------------------------------------------------------------------
module nmh_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  nmh_pkg::item_t       item,
	output logic                 push_valid,
	input  logic                 push_ready,
	output nmh_pkg::grad_t       push
);

	nmh_pkg::front_state_t state_q, state_d;

	logic [nmh_pkg::HEIGHT_W-1:0] height_store_q [nmh_pkg::MEM_DEPTH];
	logic [nmh_pkg::HEIGHT_W-1:0] rd_q;
	logic [nmh_pkg::HEIGHT_W-1:0] east_q;
	logic [nmh_pkg::HEIGHT_W-1:0] south_q;
	logic signed [nmh_pkg::DIFF_W-1:0] dhx_q;
	logic [nmh_pkg::COORD_W-1:0]  col_q, row_q;

	logic                         accept;
	logic                         mem_we, mem_re;
	logic [nmh_pkg::ADDR_W-1:0]   wr_addr, rd_addr;
	logic [nmh_pkg::COORD_W-1:0]  in_col, in_row, in_east;

	assign in_col  = item.col[nmh_pkg::COORD_W-1:0];
	assign in_row  = item.row[nmh_pkg::COORD_W-1:0];
	assign in_east = nmh_pkg::COORD_W'(in_col + nmh_pkg::COORD_W'(1));
	assign wr_addr = {in_row, in_col};
	assign accept  = item_valid && item_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nmh_pkg::F_IDLE: begin
				if (accept && item.kind == nmh_pkg::KIND_READ) state_d = nmh_pkg::F_WEST;
			end
			nmh_pkg::F_WEST:  state_d = nmh_pkg::F_SOUTH;
			nmh_pkg::F_SOUTH: state_d = nmh_pkg::F_NORTH;
			nmh_pkg::F_NORTH: state_d = nmh_pkg::F_PUSH;
			nmh_pkg::F_PUSH: begin
				if (push_ready) begin
					if (accept && item.kind == nmh_pkg::KIND_READ) state_d = nmh_pkg::F_WEST;
					else state_d = nmh_pkg::F_IDLE;
				end
			end
			default: state_d = nmh_pkg::F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_ready = 1'b0;
		push_valid = 1'b0;
		mem_re     = 1'b0;
		rd_addr    = {in_row, in_east};
		case (state_q)
			nmh_pkg::F_IDLE: begin
				item_ready = 1'b1;
				mem_re     = item_valid && item.kind == nmh_pkg::KIND_READ;
			end
			nmh_pkg::F_WEST: begin
				mem_re  = 1'b1;
				rd_addr = {row_q, nmh_pkg::COORD_W'(col_q - nmh_pkg::COORD_W'(1))};
			end
			nmh_pkg::F_SOUTH: begin
				mem_re  = 1'b1;
				rd_addr = {nmh_pkg::COORD_W'(row_q + nmh_pkg::COORD_W'(1)), col_q};
			end
			nmh_pkg::F_NORTH: begin
				mem_re  = 1'b1;
				rd_addr = {nmh_pkg::COORD_W'(row_q - nmh_pkg::COORD_W'(1)), col_q};
			end
			nmh_pkg::F_PUSH: begin
				push_valid = 1'b1;
				item_ready = push_ready;
				mem_re     = push_ready && item_valid && item.kind == nmh_pkg::KIND_READ;
			end
			default: ;
		endcase
	end

	assign mem_we    = accept && item.kind == nmh_pkg::KIND_WRITE;
	assign push.dh_x = dhx_q;
	assign push.dh_y = nmh_pkg::DIFF_W'($signed(south_q)) - nmh_pkg::DIFF_W'($signed(rd_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nmh_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) height_store_q[wr_addr] <= item.height;
		if (mem_re) rd_q <= height_store_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= in_col;
			row_q <= in_row;
		end
		case (state_q)
			nmh_pkg::F_WEST:  east_q <= rd_q;
			nmh_pkg::F_SOUTH: dhx_q <= nmh_pkg::DIFF_W'($signed(east_q))
				- nmh_pkg::DIFF_W'($signed(rd_q));
			nmh_pkg::F_NORTH: south_q <= rd_q;
			default: ;
		endcase
	end

endmodule

>>> rtl/nmh_queue.sv
// ---------------------------------------------------------------------------
// nmh_queue
// Short queue of neighbor differences between the fetch and math sides.
// ---------------------------------------------------------------------------
module nmh_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  nmh_pkg::grad_t push,
	output logic           pop_valid,
	input  logic           pop_ready,
	output nmh_pkg::grad_t pop
);

	nmh_pkg::grad_t              slot_q [nmh_pkg::QUEUE_DEPTH];
	logic [nmh_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [nmh_pkg::QCNT_W-1:0]  count_q;
	logic                        do_push, do_pop;

	assign push_ready = count_q != nmh_pkg::QCNT_W'(nmh_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop        = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [nmh_pkg::QPTR_W-1:0] next_ptr(
		input logic [nmh_pkg::QPTR_W-1:0] p
	);
		return (p == nmh_pkg::QPTR_W'(nmh_pkg::QUEUE_DEPTH - 1)) ? '0
			: nmh_pkg::QPTR_W'(p + nmh_pkg::QPTR_W'(1));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop) count_q <= nmh_pkg::QCNT_W'(count_q + nmh_pkg::QCNT_W'(1));
			else if (do_pop && !do_push) count_q <= nmh_pkg::QCNT_W'(count_q - nmh_pkg::QCNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push;
	end

endmodule

>>> rtl/nmh_back.sv
// ---------------------------------------------------------------------------
// nmh_back
// Normal math: scale the differences, normalize the vector magnitude, sum the
// squares, take an iterative square root and encode three bytes with
// restoring dividers running as parallel lanes.
// ---------------------------------------------------------------------------
module nmh_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [nmh_pkg::STRENGTH_W-1:0]   strength,
	input  logic                             grad_valid,
	output logic                             grad_ready,
	input  nmh_pkg::grad_t                   grad,
	output logic                             res_valid,
	input  logic                             res_ready,
	output nmh_pkg::result_t                 res
);

	localparam int CNT_W = $clog2(nmh_pkg::ROOT_STEPS);
	localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(nmh_pkg::LANES);
	localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(nmh_pkg::ROOT_STEPS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(nmh_pkg::BYTE_W - 1);
	localparam logic [nmh_pkg::VEC_W-1:0] UNIT = nmh_pkg::VEC_W'(1) << nmh_pkg::UNIT_SHIFT;

	nmh_pkg::back_state_t state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;

	logic signed [nmh_pkg::DIFF_W-1:0]   dhx_q, dhy_q;
	logic signed [nmh_pkg::PROD_W-1:0]   d_q, e_q;
	logic [nmh_pkg::VEC_W-1:0]           mag_q [nmh_pkg::LANES];
	logic                                neg_q [nmh_pkg::LANES];
	logic [2*nmh_pkg::VEC_W-1:0]         sq_q;
	logic [nmh_pkg::SUM_W-1:0]           sum_q, res_q;
	logic [nmh_pkg::NUM_W-1:0]           rem_q [nmh_pkg::LANES];
	logic [nmh_pkg::NUM_W-1:0]           dsh_q;
	logic [nmh_pkg::BYTE_W-1:0]          quo_q [nmh_pkg::LANES];

	logic signed [2*nmh_pkg::DIFF_W-1:0] prod_x, prod_y;
	logic [nmh_pkg::MAG_W-1:0]           abs_d, abs_e, mag_or;
	logic [1:0]                          sh;
	logic [nmh_pkg::VEC_W-1:0]           sq_src;
	logic [2*nmh_pkg::VEC_W-1:0]         sq_prod;
	logic [nmh_pkg::SUM_W-1:0]           root_bit, root_trial;
	logic [nmh_pkg::LEN_W-1:0]           len;
	logic [nmh_pkg::LEN_W:0]             enc_u [nmh_pkg::LANES];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nmh_pkg::B_IDLE: if (grad_valid) state_d = nmh_pkg::B_MUL;
			nmh_pkg::B_MUL:  state_d = nmh_pkg::B_NORM;
			nmh_pkg::B_NORM: state_d = nmh_pkg::B_SQ;
			nmh_pkg::B_SQ:   if (cnt_q == SQ_LAST) state_d = nmh_pkg::B_ROOT;
			nmh_pkg::B_ROOT: if (cnt_q == '0) state_d = nmh_pkg::B_ENC;
			nmh_pkg::B_ENC:  state_d = nmh_pkg::B_DIV;
			nmh_pkg::B_DIV:  if (cnt_q == '0) state_d = nmh_pkg::B_DONE;
			nmh_pkg::B_DONE: if (res_ready) state_d = nmh_pkg::B_IDLE;
			default:         state_d = nmh_pkg::B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		grad_ready = 1'b0;
		res_valid  = 1'b0;
		case (state_q)
			nmh_pkg::B_IDLE: grad_ready = 1'b1;
			nmh_pkg::B_DONE: res_valid  = 1'b1;
			default: ;
		endcase
	end

	assign res.normal_red   = quo_q[0];
	assign res.normal_green = quo_q[1];
	assign res.normal_blue  = quo_q[2];

	// slopes in units of 2^-20
	assign prod_x = dhx_q * $signed({1'b0, strength});
	assign prod_y = dhy_q * $signed({1'b0, strength});

	assign abs_d  = d_q[nmh_pkg::PROD_W-1] ? nmh_pkg::MAG_W'(-d_q) : nmh_pkg::MAG_W'(d_q);
	assign abs_e  = e_q[nmh_pkg::PROD_W-1] ? nmh_pkg::MAG_W'(-e_q) : nmh_pkg::MAG_W'(e_q);
	assign mag_or = abs_d | abs_e;
	// smallest shift that brings every magnitude below 2^30
	assign sh = mag_or[nmh_pkg::MAG_W-1] ? 2'd2 : (mag_or[nmh_pkg::MAG_W-2] ? 2'd1 : 2'd0);

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    sq_src = mag_q[0];
			2'd1:    sq_src = mag_q[1];
			default: sq_src = mag_q[2];
		endcase
	end
	assign sq_prod = sq_src * sq_src;

	assign root_bit   = nmh_pkg::SUM_W'(1) << {cnt_q, 1'b0};
	assign root_trial = res_q + root_bit;
	assign len        = res_q[nmh_pkg::LEN_W-1:0];

	// v + len for each lane; never negative since |v| <= len
	always_comb begin
		for (int l = 0; l < nmh_pkg::LANES; l++) begin
			enc_u[l] = neg_q[l]
				? (nmh_pkg::LEN_W+1)'(len) - (nmh_pkg::LEN_W+1)'(mag_q[l])
				: (nmh_pkg::LEN_W+1)'(len) + (nmh_pkg::LEN_W+1)'(mag_q[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nmh_pkg::B_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				nmh_pkg::B_NORM: cnt_q <= '0;
				nmh_pkg::B_SQ:   cnt_q <= (cnt_q == SQ_LAST) ? ROOT_LAST : CNT_W'(cnt_q + CNT_W'(1));
				nmh_pkg::B_ROOT: cnt_q <= CNT_W'(cnt_q - CNT_W'(1));
				nmh_pkg::B_ENC:  cnt_q <= DIV_LAST;
				nmh_pkg::B_DIV:  cnt_q <= CNT_W'(cnt_q - CNT_W'(1));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			nmh_pkg::B_IDLE: begin
				if (grad_valid) begin
					dhx_q <= grad.dh_x;
					dhy_q <= grad.dh_y;
				end
			end
			nmh_pkg::B_MUL: begin
				d_q <= prod_x[nmh_pkg::PROD_W-1:0];
				e_q <= prod_y[nmh_pkg::PROD_W-1:0];
			end
			nmh_pkg::B_NORM: begin
				mag_q[0] <= nmh_pkg::VEC_W'(abs_d >> sh);
				mag_q[1] <= nmh_pkg::VEC_W'(abs_e >> sh);
				mag_q[2] <= UNIT >> sh;
				// the normal points against the slope
				neg_q[0] <= !d_q[nmh_pkg::PROD_W-1] && d_q != '0;
				neg_q[1] <= !e_q[nmh_pkg::PROD_W-1] && e_q != '0;
				neg_q[2] <= 1'b0;
				sum_q    <= '0;
			end
			nmh_pkg::B_SQ: begin
				if (cnt_q != SQ_LAST) sq_q <= sq_prod;
				if (cnt_q != '0) sum_q <= sum_q + nmh_pkg::SUM_W'(sq_q);
				res_q <= '0;
			end
			nmh_pkg::B_ROOT: begin
				if (sum_q >= root_trial) begin
					sum_q <= sum_q - root_trial;
					res_q <= (res_q >> 1) + root_bit;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			nmh_pkg::B_ENC: begin
				for (int l = 0; l < nmh_pkg::LANES; l++) begin
					rem_q[l] <= {enc_u[l], {nmh_pkg::BYTE_W{1'b0}}}
						- nmh_pkg::NUM_W'(enc_u[l]) + nmh_pkg::NUM_W'(len);
					quo_q[l] <= '0;
				end
				// divisor 2*len aligned to the top quotient bit
				dsh_q <= {1'b0, len, {nmh_pkg::BYTE_W{1'b0}}};
			end
			nmh_pkg::B_DIV: begin
				for (int l = 0; l < nmh_pkg::LANES; l++) begin
					if (rem_q[l] >= dsh_q) begin
						rem_q[l] <= rem_q[l] - dsh_q;
						quo_q[l] <= {quo_q[l][nmh_pkg::BYTE_W-2:0], 1'b1};
					end else begin
						quo_q[l] <= {quo_q[l][nmh_pkg::BYTE_W-2:0], 1'b0};
					end
				end
				dsh_q <= dsh_q >> 1;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/normal_map_from_height_unit.sv
// ---------------------------------------------------------------------------
// normal_map_from_height_unit: toroidal height store and normal encoder.
// Write: accepted one per cycle while the fetch side is not busy with a read.
// Read: the fetch side takes one neighbor per cycle from the single-port store,
// then the math side runs the 31-step square root and 8-step dividers.
// Reset clears control and sets strength to 256; the height store is not cleared.
// ---------------------------------------------------------------------------
module normal_map_from_height_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nmh_pkg::STRENGTH_W-1:0] cfg_data,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  nmh_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output nmh_pkg::result_t               result
);

	logic [nmh_pkg::STRENGTH_W-1:0] strength_q;
	logic                           out_valid_q;
	nmh_pkg::result_t               out_q;

	logic             push_valid, push_ready;
	nmh_pkg::grad_t   push;
	logic             pop_valid, pop_ready;
	nmh_pkg::grad_t   pop;
	logic             res_valid, res_ready;
	nmh_pkg::result_t res;

	nmh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push       (push)
	);

	nmh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push       (push),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop        (pop)
	);

	nmh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.strength   (strength_q),
		.grad_valid (pop_valid),
		.grad_ready (pop_ready),
		.grad       (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// output register takes a new beat when empty or draining
	assign res_ready    = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q  <= nmh_pkg::STRENGTH_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) strength_q <= cfg_data;
			if (res_ready) out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

endmodule

>>> test/tb_normal_map_from_height_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_normal_map_from_height_unit
// Drives height writes and normal reads through the unit at several strength
// settings and checks every returned normal against a local integer model of
// the slope, normalize and byte-encode datapath. Reads only touch written
// entries; the sender bursts and the receiver stalls on its own pattern.
// ---------------------------------------------------------------------------
module tb_normal_map_from_height_unit;

	localparam int  CYCLE_LIMIT = 1_500_000;
	localparam int  DRAIN_WAIT  = 80;
	localparam int  PHASE_ITEMS = 300;
	localparam int  N_PROBES    = 5;
	localparam longint UNIT_ONE = 64'sd1 <<< nmh_pkg::UNIT_SHIFT;
	localparam longint VEC_CAP  = 64'sd1 <<< nmh_pkg::VEC_W;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           cfg_we       = 1'b0;
	logic [nmh_pkg::STRENGTH_W-1:0] cfg_data     = '0;
	logic                           item_valid   = 1'b0;
	logic                           item_ready;
	nmh_pkg::item_t                 item         = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	nmh_pkg::result_t               result;

	// Local copy of the map and register used to predict normals
	logic signed [nmh_pkg::HEIGHT_W-1:0] height_copy [0:nmh_pkg::MEM_DEPTH-1];
	bit                                  written     [0:nmh_pkg::MEM_DEPTH-1];
	int                                  strength_copy = int'(nmh_pkg::STRENGTH_RESET);

	nmh_pkg::item_t   pending_items [$];
	nmh_pkg::result_t normals_due   [$];

	int n_writes   = 0;
	int n_reads    = 0;
	int n_checked  = 0;
	int n_errors   = 0;
	int cycle_count = 0;

	int burst_left = 0;
	int gap_left   = 0;
	int stall_mode = 0;
	int mode_left  = 0;
	int stall_tick = 0;

	normal_map_from_height_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int map_index(int c, int r);
		return (r % nmh_pkg::MAP_SIZE) * nmh_pkg::MAP_SIZE + (c % nmh_pkg::MAP_SIZE);
	endfunction

	function automatic longint root_floor(longint x);
		longint root;
		longint trial;
		root = 0;
		for (int b = 30; b >= 0; b--) begin
			trial = root | (64'sd1 <<< b);
			if (trial * trial <= x)
				root = trial;
		end
		return root;
	endfunction

	function automatic logic [nmh_pkg::BYTE_W-1:0] encode_byte(longint v, longint len);
		longint q;
		q = (255 * (v + len) + len) / (2 * len);
		if (q > 255)
			q = 255;
		return q[nmh_pkg::BYTE_W-1:0];
	endfunction

	function automatic nmh_pkg::result_t normal_for_pixel(int c, int r);
		longint slope_x, slope_y, mag_x, mag_y, mag_z, peak, len;
		longint vx, vy;
		int     sh;
		nmh_pkg::result_t res;
		slope_x = (longint'(height_copy[map_index(c + 1, r)])
			- longint'(height_copy[map_index(c + nmh_pkg::MAP_SIZE - 1, r)]))
			* longint'(strength_copy);
		slope_y = (longint'(height_copy[map_index(c, r + 1)])
			- longint'(height_copy[map_index(c, r + nmh_pkg::MAP_SIZE - 1)]))
			* longint'(strength_copy);
		mag_x = slope_x < 0 ? -slope_x : slope_x;
		mag_y = slope_y < 0 ? -slope_y : slope_y;
		mag_z = UNIT_ONE;
		peak  = mag_x > mag_y ? mag_x : mag_y;
		if (mag_z > peak)
			peak = mag_z;
		// shrink all three until the largest fits the vector width
		sh = 0;
		while ((peak >> sh) >= VEC_CAP)
			sh++;
		mag_x = mag_x >> sh;
		mag_y = mag_y >> sh;
		mag_z = mag_z >> sh;
		vx  = slope_x > 0 ? -mag_x : mag_x;
		vy  = slope_y > 0 ? -mag_y : mag_y;
		len = root_floor(mag_x * mag_x + mag_y * mag_y + mag_z * mag_z);
		res.normal_red   = encode_byte(vx, len);
		res.normal_green = encode_byte(vy, len);
		res.normal_blue  = encode_byte(mag_z, len);
		return res;
	endfunction

	function automatic logic signed [nmh_pkg::HEIGHT_W-1:0] pick_height();
		int v;
		case ($urandom_range(0, 9))
			0: return {1'b1, {(nmh_pkg::HEIGHT_W-1){1'b0}}};
			1: return {1'b0, {(nmh_pkg::HEIGHT_W-1){1'b1}}};
			2, 3: return nmh_pkg::HEIGHT_W'($urandom);
			default: begin
				v = $urandom_range(0, 400);
				v = v - 200;
				return v[nmh_pkg::HEIGHT_W-1:0];
			end
		endcase
	endfunction

	// Half the coordinates land in a window that straddles the map edge
	function automatic int pick_coord();
		if ($urandom_range(0, 1) == 0)
			return (nmh_pkg::MAP_SIZE - 6 + $urandom_range(0, 11)) % nmh_pkg::MAP_SIZE;
		return $urandom_range(0, nmh_pkg::MAP_SIZE - 1);
	endfunction

	task automatic queue_write(int c, int r, logic signed [nmh_pkg::HEIGHT_W-1:0] h);
		nmh_pkg::item_t beat;
		beat.kind   = nmh_pkg::KIND_WRITE;
		beat.col    = c[nmh_pkg::FIELD_COORD_W-1:0];
		beat.row    = r[nmh_pkg::FIELD_COORD_W-1:0];
		beat.height = h;
		pending_items.push_back(beat);
		written[map_index(c, r)] = 1'b1;
		n_writes++;
	endtask

	// Fill any unwritten neighbor first; with stir set, sometimes rewrite one anyway
	task automatic queue_read(int c, int r, bit stir);
		nmh_pkg::item_t beat;
		int    nc [4];
		int    nr [4];
		nc = '{c + 1, c + nmh_pkg::MAP_SIZE - 1, c, c};
		nr = '{r, r, r + 1, r + nmh_pkg::MAP_SIZE - 1};
		for (int k = 0; k < 4; k++) begin
			if (!written[map_index(nc[k], nr[k])] || (stir && $urandom_range(0, 7) == 0))
				queue_write(nc[k] % nmh_pkg::MAP_SIZE, nr[k] % nmh_pkg::MAP_SIZE,
					pick_height());
		end
		beat.kind   = nmh_pkg::KIND_READ;
		beat.col    = c[nmh_pkg::FIELD_COORD_W-1:0];
		beat.row    = r[nmh_pkg::FIELD_COORD_W-1:0];
		beat.height = nmh_pkg::HEIGHT_W'($urandom);
		pending_items.push_back(beat);
		n_reads++;
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
		n_errors++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_valid || normals_due.size() != 0);
	endtask

	// Sender: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin : sender
		logic hold;
		if (!arst_n) begin
			item_valid <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			hold = item_valid && !item_ready;
			if (item_valid && item_ready) begin
				if (item.kind == nmh_pkg::KIND_WRITE)
					height_copy[map_index(int'(item.col), int'(item.row))] = item.height;
				else
					normals_due.push_back(normal_for_pixel(int'(item.col), int'(item.row)));
			end
			if (!hold) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item       <= pending_items.pop_front();
					item_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: switch between always-ready, random and long periodic stalls
	always @(posedge clk or negedge arst_n) begin : receiver
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_mode = 0;
			mode_left  = 0;
			stall_tick = 0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(100, 600);
			end else begin
				mode_left--;
			end
			stall_tick = (stall_tick == 24) ? 0 : stall_tick + 1;
			case (stall_mode)
				0: result_ready <= 1'b1;
				1: result_ready <= 1'($urandom_range(0, 1));
				2: result_ready <= ($urandom_range(0, 3) == 0);
				default: result_ready <= (stall_tick >= 22);
			endcase
		end
	end

	always @(posedge clk) begin : monitor
		nmh_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (normals_due.size() == 0) begin
				report_mismatch("normal with no read pending", int'(result), -1);
			end else begin
				want = normals_due.pop_front();
				if (result.normal_red !== want.normal_red)
					report_mismatch("normal_red", int'(result.normal_red),
						int'(want.normal_red));
				if (result.normal_green !== want.normal_green)
					report_mismatch("normal_green", int'(result.normal_green),
						int'(want.normal_green));
				if (result.normal_blue !== want.normal_blue)
					report_mismatch("normal_blue", int'(result.normal_blue),
						int'(want.normal_blue));
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d normals still due", cycle_count,
				normals_due.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int phase_strength [5];
		int probe_col [N_PROBES];
		int probe_row [N_PROBES];
		int goal;
		int choice;
		phase_strength = '{0, 65535, 1, 0, 383};
		phase_strength[3] = $urandom_range(2, 65534);
		probe_col = '{10, 0, 255, 100, 200};
		probe_row = '{10, 0, 255, 50, 200};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 6; p++) begin
			if (p == 0) begin
				// flat patch: straight-up normal
				queue_write(11, 10, 16'sd0);
				queue_write(9, 10, 16'sd0);
				queue_write(10, 11, 16'sd0);
				queue_write(10, 9, 16'sd0);
				queue_read(10, 10, 1'b0);
				// extreme slopes across both wrapped edges at the origin
				queue_write(1, 0, 16'sh7fff);
				queue_write(255, 0, 16'sh8000);
				queue_write(0, 1, 16'sh8000);
				queue_write(0, 255, 16'sh7fff);
				queue_read(0, 0, 1'b0);
				// far corner
				queue_write(254, 255, 16'sh7fff);
				queue_write(255, 254, 16'sh7fff);
				queue_read(255, 255, 1'b0);
				// one unit of rise in x, half in y
				queue_write(101, 50, 16'sd4096);
				queue_write(99, 50, 16'sd0);
				queue_write(100, 51, 16'sd0);
				queue_write(100, 49, 16'sd2048);
				queue_read(100, 50, 1'b0);
				// small negative x slope, positive y slope
				queue_write(201, 200, -16'sd100);
				queue_write(199, 200, 16'sd100);
				queue_write(200, 201, 16'sd300);
				queue_write(200, 199, -16'sd300);
				queue_read(200, 200, 1'b0);
			end else begin
				@(posedge clk);
				cfg_we   <= 1'b1;
				cfg_data <= phase_strength[p-1][nmh_pkg::STRENGTH_W-1:0];
				@(posedge clk);
				cfg_we <= 1'b0;
				strength_copy = phase_strength[p-1];
				for (int k = 0; k < N_PROBES; k++)
					queue_read(probe_col[k], probe_row[k], 1'b0);
			end

			goal = n_writes + n_reads + PHASE_ITEMS;
			while (n_writes + n_reads < goal) begin
				choice = $urandom_range(0, 99);
				if (choice < 10)
					queue_write($urandom_range(0, nmh_pkg::MAP_SIZE - 1),
						$urandom_range(0, nmh_pkg::MAP_SIZE - 1),
						nmh_pkg::HEIGHT_W'($urandom));
				else if (choice < 35)
					queue_write(pick_coord(), pick_coord(), pick_height());
				else
					queue_read(pick_coord(), pick_coord(), 1'b1);
			end

			// hold the next phase until every normal is back and the unit is quiet
			wait_drained();
			repeat (DRAIN_WAIT) @(posedge clk);
		end

		$display("Ran %0d height writes and %0d normal reads over six strength settings",
			n_writes, n_reads);
		$display("Strengths included 0, 65535, 1 and 256; %0d normals checked, %0d mismatches",
			n_checked, n_errors);
		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
